/* hw/rtl/sbp_pkg.sv */
// Shared types, constants and tables for the six-button pad scan-code block.
package sbp_pkg;

   localparam int WORD_W              = 13;
   localparam int SEQ_COUNT           = 14;
   localparam int SEQ_IDX_W           = 4;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [7:0] RESET_READ_DELAY_MS  = 8'd5;
   localparam logic [7:0] RESET_PRESS_PREFIX   = 8'he2;
   localparam logic [7:0] RESET_RELEASE_PREFIX = 8'hf0;
   localparam logic [7:0] RESET_CODE_BASE      = 8'h40;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_READ_DELAY_MS  = 2'd0,
      CSR_PRESS_PREFIX   = 2'd1,
      CSR_RELEASE_PREFIX = 2'd2,
      CSR_CODE_BASE      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PRESS,
      S_RELEASE,
      S_CODE
   } back_state_type;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [SEQ_COUNT-1:0] seq_mask_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [5:0]  pins_phase2;
      logic [5:0]  pins_phase3;
      logic [5:0]  pins_phase4;
      logic [5:0]  pins_phase5;
   } req_type;

   typedef struct packed {
      logic [7:0] scan_byte;
      logic       is_last;
      word_type   pad_word;
   } rsp_type;

   typedef struct packed {
      logic [7:0] read_delay_ms;
      logic [7:0] press_prefix;
      logic [7:0] release_prefix;
      logic [7:0] code_base;
   } cfg_type;

   // One poll's worth of work for the emitter
   typedef struct packed {
      word_type     word;
      seq_mask_type pend;   // sequences whose button changed
      seq_mask_type rel;    // button is up in the new word
   } job_type;

   // Button word bit watched by each sequence, in emission order
   function automatic logic [3:0] seq_bit(input logic [SEQ_IDX_W-1:0] k);
      logic [3:0] b;
      case (k)
         4'd0:    b = 4'd1;
         4'd1:    b = 4'd2;
         4'd2:    b = 4'd3;
         4'd3:    b = 4'd4;
         4'd4:    b = 4'd5;
         4'd5:    b = 4'd6;
         4'd6:    b = 4'd7;
         4'd7:    b = 4'd8;
         4'd8:    b = 4'd9;
         4'd9:    b = 4'd10;
         4'd10:   b = 4'd11;
         4'd11:   b = 4'd7;    // B alias, sent as A
         4'd12:   b = 4'd8;    // C alias, sent as Z
         4'd13:   b = 4'd12;
         default: b = 4'd0;
      endcase
      return b;
   endfunction

   // Code offset from code_base of each sequence
   function automatic logic [3:0] seq_off(input logic [SEQ_IDX_W-1:0] k);
      logic [3:0] o;
      case (k)
         4'd0:    o = 4'd2;
         4'd1:    o = 4'd3;
         4'd2:    o = 4'd0;
         4'd3:    o = 4'd1;
         4'd4:    o = 4'd4;
         4'd5:    o = 4'd6;
         4'd6:    o = 4'd7;
         4'd7:    o = 4'd8;
         4'd8:    o = 4'd9;
         4'd9:    o = 4'd10;
         4'd10:   o = 4'd11;
         4'd11:   o = 4'd6;
         4'd12:   o = 4'd11;
         4'd13:   o = 4'd5;
         default: o = 4'd0;
      endcase
      return o;
   endfunction

   // Index of the lowest set bit
   function automatic logic [SEQ_IDX_W-1:0] lowest_set(input seq_mask_type m);
      logic [SEQ_IDX_W-1:0] idx;
      idx = '0;
      for (int i = SEQ_COUNT - 1; i >= 0; i--) begin
         if (m[i]) idx = SEQ_IDX_W'(i);
      end
      return idx;
   endfunction

endpackage

/* hw/rtl/sbp_front.sv */
// Front end: accepts polls, applies the read delay, decodes pins and queues change jobs.
module sbp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      read_delay_ms,
   input  logic            req_valid,
   input  sbp_pkg::req_type req_data,
   output logic            req_stall,
   input  logic            queue_full,
   output logic            push,
   output sbp_pkg::job_type push_job
);

   logic [31:0]       last_ms_ff, last_ms_in;
   sbp_pkg::word_type rep_ff, rep_in;
   logic              accept;
   logic              due;
   logic [31:0]       diff;
   sbp_pkg::word_type w;
   logic              connected;
   logic              six_flag;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Wrapping time check against the last real read
   assign diff = req_data.now_ms - last_ms_ff;
   assign due  = diff >= {24'd0, read_delay_ms};

   // Pin decode, pins are active low; X, Y, Z and mode follow the six-button
   // pattern even while the pad reads as unplugged
   always_comb begin
      w         = '0;
      connected = !req_data.pins_phase2[2] && !req_data.pins_phase2[3];
      six_flag  = !req_data.pins_phase4[0] && !req_data.pins_phase4[1];
      w[0]      = connected;
      w[6]      = connected && !req_data.pins_phase2[4];
      w[5]      = connected && !req_data.pins_phase2[5];
      w[1]      = !req_data.pins_phase3[0];
      w[2]      = !req_data.pins_phase3[1];
      w[3]      = !req_data.pins_phase3[2];
      w[4]      = !req_data.pins_phase3[3];
      w[7]      = !req_data.pins_phase3[4];
      w[8]      = !req_data.pins_phase3[5];
      w[11]     = six_flag && !req_data.pins_phase5[0];
      w[10]     = six_flag && !req_data.pins_phase5[1];
      w[9]      = six_flag && !req_data.pins_phase5[2];
      w[12]     = six_flag && !req_data.pins_phase5[3];
   end

   // Changed and released masks per emitted sequence
   always_comb begin
      push_job.word = w;
      for (int k = 0; k < sbp_pkg::SEQ_COUNT; k++) begin
         push_job.pend[k] = w[sbp_pkg::seq_bit(sbp_pkg::SEQ_IDX_W'(k))]
                          ^ rep_ff[sbp_pkg::seq_bit(sbp_pkg::SEQ_IDX_W'(k))];
         push_job.rel[k]  = !w[sbp_pkg::seq_bit(sbp_pkg::SEQ_IDX_W'(k))];
      end
   end

   assign push = accept && due && (push_job.pend != '0);

   // State update on a real read
   always_comb begin
      last_ms_in = last_ms_ff;
      rep_in     = rep_ff;
      if (accept && due) begin
         last_ms_in = req_data.now_ms;
         rep_in     = w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ms_ff <= '0;
         rep_ff     <= '0;
      end else begin
         last_ms_ff <= last_ms_in;
         rep_ff     <= rep_in;
      end
   end

   a_push_has_work: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.pend != '0 && !queue_full))
      else $error("front pushed an empty job or into a full queue");

endmodule

/* hw/rtl/sbp_queue.sv */
// Small job queue between the front end and the emitter.
module sbp_queue #(
   parameter int DEPTH = sbp_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sbp_pkg::job_type push_job,
   input  logic             pop,
   output sbp_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sbp_pkg::job_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = count_ff == '0;
   assign full     = count_ff == CNT_W'(DEPTH);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");

endmodule

/* hw/rtl/sbp_back.sv */
// Emitter: walks one job's changed buttons and sends prefix, release and code bytes.
module sbp_back (
   input  logic             clock,
   input  logic             reset,
   input  sbp_pkg::cfg_type cfg,
   input  sbp_pkg::job_type head_job,
   input  logic             queue_empty,
   output logic             pop,
   output logic             rsp_valid,
   output sbp_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   sbp_pkg::back_state_type      state_ff, state_in;
   sbp_pkg::word_type            word_ff, word_in;
   sbp_pkg::seq_mask_type        pend_ff, pend_in;
   sbp_pkg::seq_mask_type        rel_ff, rel_in;
   logic                         out_valid_ff, out_valid_in;
   sbp_pkg::rsp_type             out_ff, out_in;
   logic [sbp_pkg::SEQ_IDX_W-1:0] k;
   sbp_pkg::seq_mask_type        pend_left;
   logic                         advance;
   logic                         final_byte;
   logic [7:0]                   byte_val;

   assign k          = sbp_pkg::lowest_set(pend_ff);
   assign pend_left  = pend_ff & ~(sbp_pkg::seq_mask_type'(1) << k);
   assign final_byte = pend_left == '0;
   assign advance    = (state_ff != sbp_pkg::S_IDLE) && (!out_valid_ff || !rsp_stall);
   assign pop        = (state_ff == sbp_pkg::S_IDLE) && !queue_empty;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbp_pkg::S_IDLE: begin
            if (!queue_empty) state_in = sbp_pkg::S_PRESS;
         end
         sbp_pkg::S_PRESS: begin
            if (advance) state_in = rel_ff[k] ? sbp_pkg::S_RELEASE : sbp_pkg::S_CODE;
         end
         sbp_pkg::S_RELEASE: begin
            if (advance) state_in = sbp_pkg::S_CODE;
         end
         sbp_pkg::S_CODE: begin
            if (advance) state_in = final_byte ? sbp_pkg::S_IDLE : sbp_pkg::S_PRESS;
         end
         default: state_in = sbp_pkg::S_IDLE;
      endcase
   end

   // Byte selection, job register and output register
   always_comb begin
      word_in      = word_ff;
      pend_in      = pend_ff;
      rel_in       = rel_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      byte_val     = cfg.press_prefix;
      case (state_ff)
         sbp_pkg::S_IDLE: begin
            if (pop) begin
               word_in = head_job.word;
               pend_in = head_job.pend;
               rel_in  = head_job.rel;
            end
         end
         sbp_pkg::S_PRESS:   byte_val = cfg.press_prefix;
         sbp_pkg::S_RELEASE: byte_val = cfg.release_prefix;
         sbp_pkg::S_CODE: begin
            byte_val = cfg.code_base + {4'd0, sbp_pkg::seq_off(k)};
            if (advance) pend_in = pend_left;
         end
         default: byte_val = cfg.press_prefix;
      endcase
      if (advance) begin
         out_valid_in     = 1'b1;
         out_in.scan_byte = byte_val;
         out_in.is_last   = (state_ff == sbp_pkg::S_CODE) && final_byte;
         out_in.pad_word  = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbp_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
         pend_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rel_ff  <= rel_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sbp_pkg::S_IDLE) |-> (pend_ff != '0))
      else $error("emitter busy with no pending sequence");

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff == sbp_pkg::S_CODE && final_byte) |=>
         (state_ff == sbp_pkg::S_IDLE && rsp_valid && rsp_data.is_last))
      else $error("final byte did not end the job");

endmodule

/* hw/rtl/six_button_pad_to_scancode_top.sv */
// Top level of the six-button pad to keyboard scan-code converter.
// Each poll item carries a millisecond time and the active-low pin samples of read
// phases two to five. The front end takes one poll per cycle while the job queue
// (QUEUE_DEPTH entries) has room; a poll within read_delay_ms of the last real read,
// or one that changes no button, queues nothing and yields no item. A poll with
// changes becomes a job for the emitter, which pulls the job when idle and then gives
// one byte per cycle while its output is not stalled: two bytes for each pressed button
// and three for each released one, so up to 42 bytes for a poll. Results leave through
// a single output register. Configuration registers are written through the csr_ port
// and registered; the front end and the emitter use the registered values, also mid-job.
module six_button_pad_to_scancode_top #(
   parameter int QUEUE_DEPTH = sbp_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  sbp_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output sbp_pkg::rsp_type rsp_data,
   input  logic             rsp_stall,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_data
);

   sbp_pkg::cfg_type cfg_ff, cfg_in;
   logic             push, pop, q_empty, q_full;
   sbp_pkg::job_type push_job, head_job;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (sbp_pkg::csr_index_type'(csr_index))
            sbp_pkg::CSR_READ_DELAY_MS:  cfg_in.read_delay_ms  = csr_data;
            sbp_pkg::CSR_PRESS_PREFIX:   cfg_in.press_prefix   = csr_data;
            sbp_pkg::CSR_RELEASE_PREFIX: cfg_in.release_prefix = csr_data;
            sbp_pkg::CSR_CODE_BASE:      cfg_in.code_base      = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_delay_ms  <= sbp_pkg::RESET_READ_DELAY_MS;
         cfg_ff.press_prefix   <= sbp_pkg::RESET_PRESS_PREFIX;
         cfg_ff.release_prefix <= sbp_pkg::RESET_RELEASE_PREFIX;
         cfg_ff.code_base      <= sbp_pkg::RESET_CODE_BASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .read_delay_ms (cfg_ff.read_delay_ms),
      .req_valid     (req_valid),
      .req_data      (req_data),
      .req_stall     (req_stall),
      .queue_full    (q_full),
      .push          (push),
      .push_job      (push_job)
   );

   sbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   sbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_job    (head_job),
      .queue_empty (q_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

endmodule
